// ===== design/grf_pkg.sv =====
// ----------------------------------------------------------------------------
// grf_pkg: shared types and constants for the gradient rectangle fill
// Register map, size limits, the queued pixel request and the divider sizing.
// ----------------------------------------------------------------------------
package grf_pkg;

  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM);        // column / row counter
  localparam int DIM_W   = $clog2(MAX_DIM + 1);    // effective size
  localparam int POS_W   = CNT_W + 1;              // counter with carry room

  localparam int ORG_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int PITCH_W = 16;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = COLOR_W / CH_W;
  localparam int XY_W    = ((ORG_W > CNT_W) ? ORG_W : CNT_W) + 1;
  localparam int BPP_SHIFT = 2;                    // 4 bytes per pixel

  // serial divider: dividend is k * |end - start|
  localparam int PW      = CNT_W + CH_W;
  localparam int STEP_W  = $clog2(PW + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int NUM_REGS = 8;
  localparam int REG_IW   = $clog2(NUM_REGS);
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);

  localparam logic [REG_IW-1:0] REG_ORIGIN_X    = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_ORIGIN_Y    = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_RECT_WIDTH  = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_RECT_HEIGHT = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_ROW_PITCH   = REG_IW'(4);
  localparam logic [REG_IW-1:0] REG_START_COLOR = REG_IW'(5);
  localparam logic [REG_IW-1:0] REG_END_COLOR   = REG_IW'(6);
  localparam logic [REG_IW-1:0] REG_VERTICAL    = REG_IW'(7);

  typedef struct packed {
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic [PITCH_W-1:0] row_pitch;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic               vertical;
  } cfg_t;

  // one pixel request handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             last;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_HOLD
  } back_state_e;

  // zero counts as one, anything above MAX_DIM clamps
  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/grf_front.sv =====
// ----------------------------------------------------------------------------
// grf_front: pixel walker
// Holds the column/row counters, resolves restart and out-of-range wrap,
// flags the last pixel and queues one request per accepted input.
// ----------------------------------------------------------------------------
module grf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grf_pkg::cfg_t cfg_i,
  input  logic          push_i,
  input  logic          restart_i,
  input  logic          fifo_full_i,
  output logic          fifo_wr_o,
  output grf_pkg::item_t item_o
);
  import grf_pkg::*;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [POS_W-1:0] col_t, row_t, w_t, h_t;

  assign fifo_wr_o = push_i & ~fifo_full_i;
  assign w_t = POS_W'(eff_size(cfg_i.rect_width));
  assign h_t = POS_W'(eff_size(cfg_i.rect_height));

  always_comb begin
    col_t = restart_i ? '0 : POS_W'(col_q);
    row_t = restart_i ? '0 : POS_W'(row_q);
    if (col_t >= w_t) begin
      col_t = '0;
      row_t = row_t + POS_W'(1);
    end
    if (row_t >= h_t) begin
      row_t = '0;
    end

    item_o.col  = col_t[CNT_W-1:0];
    item_o.row  = row_t[CNT_W-1:0];
    item_o.last = (col_t == w_t - POS_W'(1)) && (row_t == h_t - POS_W'(1));

    if (col_t + POS_W'(1) < w_t) begin
      col_d = col_t[CNT_W-1:0] + CNT_W'(1);
      row_d = row_t[CNT_W-1:0];
    end else begin
      col_d = '0;
      row_d = (row_t + POS_W'(1) < h_t) ? row_t[CNT_W-1:0] + CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (fifo_wr_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== design/grf_fifo.sv =====
// ----------------------------------------------------------------------------
// grf_fifo: request queue between walker and pixel engine
// Small register queue; lets the walker take inputs while the engine divides.
// ----------------------------------------------------------------------------
module grf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  grf_pkg::item_t wdata_i,
  input  logic           rd_i,
  output grf_pkg::item_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import grf_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign full_o  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= (32'(wp_q) == FIFO_DEPTH - 1) ? '0 : wp_q + FIFO_AW'(1);
      end
      if (rd_i) begin
        rp_q <= (32'(rp_q) == FIFO_DEPTH - 1) ? '0 : rp_q + FIFO_AW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + FIFO_CW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - FIFO_CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= FIFO_DEPTH)
    else $error("queue count above depth");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> (cnt_q == $past(cnt_q) + FIFO_CW'(1)))
    else $error("queue count missed a write");
  a_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("queue read while empty");
`endif

endmodule

// ===== design/grf_back.sv =====
// ----------------------------------------------------------------------------
// grf_back: pixel engine
// Takes one request, forms the byte address and runs four restoring
// dividers (one per channel, shared divisor) a bit per cycle for the color.
// ----------------------------------------------------------------------------
module grf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  grf_pkg::cfg_t               cfg_i,
  input  grf_pkg::item_t              item_i,
  input  logic                        fifo_empty_i,
  output logic                        fifo_rd_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [grf_pkg::ADDR_W-1:0]  byte_address_o,
  output logic [grf_pkg::COLOR_W-1:0] pixel_argb_o,
  output logic                        last_pixel_o
);
  import grf_pkg::*;

  back_state_e state_q, state_d;

  item_t              item_q;
  logic [STEP_W-1:0]  step_q;
  logic [DIM_W-1:0]   divisor_q;
  logic               n_one_q;
  logic [ADDR_W-1:0]  yprod_q, xoff_q;
  logic [PW-1:0]      dvd_q [NUM_CH];
  logic [PW-1:0]      quo_q [NUM_CH];
  logic [DIM_W-1:0]   rem_q [NUM_CH];

  logic [PW-1:0]      dvd_d [NUM_CH];
  logic [PW-1:0]      quo_d [NUM_CH];
  logic [DIM_W-1:0]   rem_d [NUM_CH];
  logic [PW-1:0]      prod  [NUM_CH];
  logic [COLOR_W-1:0] color;

  logic               out_valid_q;
  logic               take, load, step, finish;

  logic [CNT_W-1:0]   k;
  logic [DIM_W-1:0]   n;
  logic [XY_W-1:0]    xpos, ypos;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!fifo_empty_i) state_d = BK_LOAD;
      BK_LOAD: state_d = BK_DIV;
      BK_DIV:  if (32'(step_q) == PW - 1) state_d = BK_HOLD;
      BK_HOLD: if (!out_valid_q || pop_i) state_d = BK_IDLE;
    endcase
  end

  // controls
  always_comb begin
    take   = 1'b0;
    load   = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      BK_IDLE: take   = !fifo_empty_i;
      BK_LOAD: load   = 1'b1;
      BK_DIV:  step   = 1'b1;
      BK_HOLD: finish = !out_valid_q || pop_i;
    endcase
  end

  assign fifo_rd_o = take;
  assign empty_o   = !out_valid_q;

  assign k    = cfg_i.vertical ? item_q.row : item_q.col;
  assign n    = cfg_i.vertical ? eff_size(cfg_i.rect_height) : eff_size(cfg_i.rect_width);
  assign xpos = XY_W'(cfg_i.origin_x) + XY_W'(item_q.col);
  assign ypos = XY_W'(cfg_i.origin_y) + XY_W'(item_q.row);

  always_comb begin
    logic [CH_W-1:0]  s, e, d, q8;
    logic [DIM_W:0]   tr;
    for (int c = 0; c < NUM_CH; c++) begin
      s = cfg_i.start_color[c*CH_W +: CH_W];
      e = cfg_i.end_color[c*CH_W +: CH_W];
      d = (e >= s) ? e - s : s - e;
      prod[c] = PW'(k) * PW'(d);

      // one restoring divide step
      tr = {rem_q[c], dvd_q[c][PW-1]};
      if (tr >= {1'b0, divisor_q}) begin
        rem_d[c] = DIM_W'(tr - {1'b0, divisor_q});
        quo_d[c] = {quo_q[c][PW-2:0], 1'b1};
      end else begin
        rem_d[c] = tr[DIM_W-1:0];
        quo_d[c] = {quo_q[c][PW-2:0], 1'b0};
      end
      dvd_d[c] = {dvd_q[c][PW-2:0], 1'b0};

      q8 = quo_q[c][CH_W-1:0];
      if (n_one_q) begin
        color[c*CH_W +: CH_W] = s;
      end else if (e >= s) begin
        color[c*CH_W +: CH_W] = s + q8;
      end else begin
        color[c*CH_W +: CH_W] = s - q8;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= '0;
      end else if (step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
    if (load) begin
      divisor_q <= n - DIM_W'(1);
      n_one_q   <= (n <= DIM_W'(1));
      yprod_q   <= ADDR_W'(ypos) * ADDR_W'(cfg_i.row_pitch);
      xoff_q    <= ADDR_W'(xpos) << BPP_SHIFT;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (load) begin
        dvd_q[c] <= prod[c];
        quo_q[c] <= '0;
        rem_q[c] <= '0;
      end else if (step) begin
        dvd_q[c] <= dvd_d[c];
        quo_q[c] <= quo_d[c];
        rem_q[c] <= rem_d[c];
      end
    end
    if (finish) begin
      byte_address_o <= yprod_q + xoff_q;
      pixel_argb_o   <= color;
      last_pixel_o   <= item_q.last;
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (32'(step_q) < PW))
    else $error("divider ran past its step count");
  a_load_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_LOAD) |=> (state_q == BK_DIV))
    else $error("load not followed by divide");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == BK_HOLD))
    else $error("result appeared without a finished divide");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_rd_o |-> (state_q == BK_IDLE))
    else $error("request taken while busy");
`endif

endmodule

// ===== design/gradient_rect_fill.sv =====
// ----------------------------------------------------------------------------
// gradient_rect_fill: linear gradient rectangle fill, 32-bit ARGB
// Walks the rectangle in raster order and emits address, color and
// last-pixel mark for each request.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  request   push / full                 restart_i
//  result    empty / pop                 byte_address_o, pixel_argb_o,
//                                        last_pixel_o
//  config    psel penable pwrite pready  paddr, pwdata, prdata
//
//  The pixel engine computes each color with the bit-serial restoring
//  dividers (one quotient bit per cycle per channel).
//  A two-entry queue and the result register let requests come in while the
//  engine works or a result waits; full rises once the queue is full.
//  Reset is asynchronous; counters return to the first pixel and the
//  registers to their defaults.
// ----------------------------------------------------------------------------
module gradient_rect_fill (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        restart_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [grf_pkg::ADDR_W-1:0]  byte_address_o,
  output logic [grf_pkg::COLOR_W-1:0] pixel_argb_o,
  output logic                        last_pixel_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import grf_pkg::*;

  cfg_t              cfg_q;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  item_t             front_item, queue_item;
  logic              fifo_wr, fifo_rd, fifo_full, fifo_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.rect_width  <= SIZE_W'(1);
      cfg_q.rect_height <= SIZE_W'(1);
      cfg_q.row_pitch   <= '0;
      cfg_q.start_color <= '0;
      cfg_q.end_color   <= '0;
      cfg_q.vertical    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:    cfg_q.origin_y    <= pwdata[ORG_W-1:0];
        REG_RECT_WIDTH:  cfg_q.rect_width  <= pwdata[SIZE_W-1:0];
        REG_RECT_HEIGHT: cfg_q.rect_height <= pwdata[SIZE_W-1:0];
        REG_ROW_PITCH:   cfg_q.row_pitch   <= pwdata[PITCH_W-1:0];
        REG_START_COLOR: cfg_q.start_color <= pwdata[COLOR_W-1:0];
        REG_END_COLOR:   cfg_q.end_color   <= pwdata[COLOR_W-1:0];
        REG_VERTICAL:    cfg_q.vertical    <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:    prdata = 32'(cfg_q.origin_x);
      REG_ORIGIN_Y:    prdata = 32'(cfg_q.origin_y);
      REG_RECT_WIDTH:  prdata = 32'(cfg_q.rect_width);
      REG_RECT_HEIGHT: prdata = 32'(cfg_q.rect_height);
      REG_ROW_PITCH:   prdata = 32'(cfg_q.row_pitch);
      REG_START_COLOR: prdata = 32'(cfg_q.start_color);
      REG_END_COLOR:   prdata = 32'(cfg_q.end_color);
      REG_VERTICAL:    prdata = 32'(cfg_q.vertical);
    endcase
  end

  assign full = fifo_full;

  grf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .restart_i   (restart_i),
    .fifo_full_i (fifo_full),
    .fifo_wr_o   (fifo_wr),
    .item_o      (front_item)
  );

  grf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_wr),
    .wdata_i (front_item),
    .rd_i    (fifo_rd),
    .rdata_o (queue_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  grf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_i         (queue_item),
    .fifo_empty_i   (fifo_empty),
    .fifo_rd_o      (fifo_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .byte_address_o (byte_address_o),
    .pixel_argb_o   (pixel_argb_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule
